/* src/bctd_pkg.sv */
// ----------------------------------------------------------------------------
// bctd_pkg
// Shared types and constants of the block cache tag directory.
// ----------------------------------------------------------------------------
package bctd_pkg;

  localparam int DEFAULT_ENTRIES = 64;
  localparam int MAX_RESULTS     = 64;
  localparam int CNT_RES_W       = $clog2(MAX_RESULTS + 1);
  localparam int SLOT_W          = 6;
  localparam int LANES           = 4;

  // index lanes carried along the cell row
  localparam int LANE_HIT  = 0;
  localparam int LANE_INV  = 1;
  localparam int LANE_BEST = 2;
  localparam int LANE_WB   = 3;

  localparam logic [2:0] OP_READ      = 3'd0;
  localparam logic [2:0] OP_WRITE     = 3'd1;
  localparam logic [2:0] OP_INV_FILE  = 3'd2;
  localparam logic [2:0] OP_FLUSH     = 3'd3;
  localparam logic [2:0] OP_INV_ALL   = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DISABLED = 2'd1;
  localparam logic [1:0] ST_NO_FILL  = 2'd2;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] file_tag;
    logic [31:0] block_offset;
    logic        new_request;
    logic        allow_fill;
    logic        mark_dirty;
    logic        flush_first;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              fill_needed;
    logic [1:0]        status;
    logic              writeback_valid;
    logic [31:0]       writeback_tag;
    logic [31:0]       writeback_offset;
    logic              last;
  } res_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_FILL,
    CMD_TOUCH,
    CMD_CLEAN,
    CMD_BULK
  } cmd_t;

  // item and update command broadcast to every cell
  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] file_tag;
    logic [31:0] block_offset;
    logic        mark_dirty;
    logic        flush_first;
    logic [31:0] clock;
    cmd_t        cmd;
  } bcast_t;

  // search record handed from cell to cell
  typedef struct packed {
    logic        hit;
    logic        inv;
    logic        best_valid;
    logic [31:0] oldest_use;
    logic [31:0] best_tag;
    logic [31:0] best_off;
    logic        best_dirty;
    logic        wb;
    logic [31:0] wb_tag;
    logic [31:0] wb_off;
  } carry_t;

endpackage

/* src/bctd_stream_if.sv */
// ----------------------------------------------------------------------------
// bctd_stream_if
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
interface bctd_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* src/bctd_cell.sv */
// ----------------------------------------------------------------------------
// bctd_cell
// One directory entry plus one hop of the search record along the row.
// ----------------------------------------------------------------------------
module bctd_cell #(
  parameter int ENTRIES    = bctd_pkg::DEFAULT_ENTRIES,
  parameter int CELL_INDEX = 0
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  bctd_pkg::bcast_t                          bc,
  input  logic [$clog2(ENTRIES)-1:0]                cmd_idx,
  input  bctd_pkg::carry_t                          carry_in,
  input  logic [bctd_pkg::LANES-1:0][$clog2(ENTRIES)-1:0] idx_in,
  output bctd_pkg::carry_t                          carry_out,
  output logic [bctd_pkg::LANES-1:0][$clog2(ENTRIES)-1:0] idx_out
);
  localparam int IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

  logic [31:0] tag;
  logic [31:0] off;
  logic [31:0] last_use;
  logic        dirty;

  logic        valid;
  logic        tag_eq;
  logic        blk_eq;
  logic        sel;
  logic        wb_need;
  logic        mine;
  bctd_pkg::carry_t carry_next;
  logic [bctd_pkg::LANES-1:0][IDX_W-1:0] idx_next;

  assign valid   = last_use != 32'd0;
  assign tag_eq  = tag == bc.file_tag;
  assign blk_eq  = tag_eq && (off == bc.block_offset);
  assign sel     = valid && ((bc.opcode == bctd_pkg::OP_INV_ALL) || tag_eq);
  assign wb_need = sel && dirty && ((bc.opcode == bctd_pkg::OP_FLUSH) || bc.flush_first);
  assign mine    = cmd_idx == MY_IDX;

  always_comb begin
    carry_next = carry_in;
    idx_next   = idx_in;
    if (!carry_in.hit && valid && blk_eq) begin
      carry_next.hit              = 1'b1;
      idx_next[bctd_pkg::LANE_HIT] = MY_IDX;
    end
    if (!carry_in.inv && !valid) begin
      carry_next.inv              = 1'b1;
      idx_next[bctd_pkg::LANE_INV] = MY_IDX;
    end
    // strict compare keeps the lowest index on a tie
    if (valid && (!carry_in.best_valid || (last_use < carry_in.oldest_use))) begin
      carry_next.best_valid        = 1'b1;
      carry_next.oldest_use        = last_use;
      carry_next.best_tag          = tag;
      carry_next.best_off          = off;
      carry_next.best_dirty        = dirty;
      idx_next[bctd_pkg::LANE_BEST] = MY_IDX;
    end
    if (!carry_in.wb && wb_need) begin
      carry_next.wb              = 1'b1;
      carry_next.wb_tag          = tag;
      carry_next.wb_off          = off;
      idx_next[bctd_pkg::LANE_WB] = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    carry_out <= carry_next;
    idx_out   <= idx_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_use <= 32'd0;
      dirty    <= 1'b0;
    end else begin
      unique case (bc.cmd)
        bctd_pkg::CMD_FILL: begin
          if (mine) begin
            last_use <= bc.clock;
            dirty    <= (bc.opcode == bctd_pkg::OP_WRITE) && bc.mark_dirty;
          end
        end
        bctd_pkg::CMD_TOUCH: begin
          if (mine) begin
            last_use <= bc.clock;
            if (bc.opcode == bctd_pkg::OP_WRITE) begin
              dirty <= bc.mark_dirty;
            end
          end
        end
        bctd_pkg::CMD_CLEAN: begin
          if (mine) begin
            dirty <= 1'b0;
            if (bc.opcode != bctd_pkg::OP_FLUSH) begin
              last_use <= 32'd0;
            end
          end
        end
        bctd_pkg::CMD_BULK: begin
          // entries still owing a write-back past the result limit stay as they are
          if (sel && !wb_need) begin
            dirty <= 1'b0;
            if (bc.opcode != bctd_pkg::OP_FLUSH) begin
              last_use <= 32'd0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((bc.cmd == bctd_pkg::CMD_FILL) && mine) begin
      tag <= bc.file_tag;
      off <= bc.block_offset;
    end
  end

endmodule

/* src/block_cache_tag_directory_top.sv */
// ----------------------------------------------------------------------------
// block_cache_tag_directory_top
// Fully associative write-back block cache directory with LRU replacement.
// ----------------------------------------------------------------------------
//  channel   dir  payload              note
//  request   in   bctd_pkg::req_t      read, write, invalidate, flush
//  result    out  bctd_pkg::res_t      one or more per request, last marks end
//  cfg       in   logic                cache_enable
//
// A request is taken in IDLE, then the search record crosses the ENTRIES cells
// one cell per cycle in SCAN, then DONE decides and EMIT loads the result register.
// Invalidate and flush rescan once per write-back. Reset clears every entry at
// once; clock restarts at one. A stalled result holds the sequencer; cfg is
// always ready.
// ----------------------------------------------------------------------------
module block_cache_tag_directory_top #(
  parameter int ENTRIES = bctd_pkg::DEFAULT_ENTRIES
) (
  input logic          clk,
  input logic          rst,
  bctd_stream_if.sink   request,
  bctd_stream_if.source result,
  bctd_stream_if.sink   cfg
);
  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES);
  localparam int RES_W = bctd_pkg::CNT_RES_W;

  typedef enum logic [1:0] {IDLE, SCAN, DONE, EMIT} state_t;

  state_t              state;
  state_t              ret_state;
  bctd_pkg::req_t      item;
  logic [31:0]         clock;
  logic [CNT_W-1:0]    cnt;
  logic [RES_W-1:0]    n_res;
  logic                pend_valid;
  logic [31:0]         pend_tag;
  logic [31:0]         pend_off;
  bctd_pkg::res_t      res_q;
  bctd_pkg::res_t      out_q;
  logic                out_valid;
  logic                enable;

  bctd_pkg::bcast_t    bc;
  logic [IDX_W-1:0]    cmd_idx;
  bctd_pkg::carry_t    chain_c [ENTRIES+1];
  logic [bctd_pkg::LANES-1:0][IDX_W-1:0] chain_i [ENTRIES+1];
  bctd_pkg::carry_t    ce;
  logic [bctd_pkg::LANES-1:0][IDX_W-1:0] ie;

  bctd_pkg::cmd_t      cmd;
  bctd_pkg::res_t      res_done;
  bctd_pkg::res_t      res_start;
  bctd_pkg::res_t      res_wb;
  logic                more;
  logic                rw;
  logic                load;

  assign ce = chain_c[ENTRIES];
  assign ie = chain_i[ENTRIES];
  assign chain_c[0] = '0;
  assign chain_i[0] = '0;

  assign rw   = (item.opcode == bctd_pkg::OP_READ) || (item.opcode == bctd_pkg::OP_WRITE);
  assign load = (state == EMIT) && (!out_valid || result.ready);

  assign request.ready  = state == IDLE;
  assign cfg.ready      = 1'b1;
  assign result.valid   = out_valid;
  assign result.payload = out_q;

  always_comb begin
    cmd      = bctd_pkg::CMD_NONE;
    cmd_idx  = '0;
    res_done = '0;
    res_done.last = 1'b1;
    more     = 1'b0;
    if (state == DONE) begin
      if (rw) begin
        if (ce.hit) begin
          cmd          = bctd_pkg::CMD_TOUCH;
          cmd_idx      = ie[bctd_pkg::LANE_HIT];
          res_done.hit = 1'b1;
          res_done.slot = bctd_pkg::SLOT_W'(ie[bctd_pkg::LANE_HIT]);
        end else if ((item.opcode == bctd_pkg::OP_READ) && !item.allow_fill) begin
          res_done.status = bctd_pkg::ST_NO_FILL;
        end else begin
          cmd = bctd_pkg::CMD_FILL;
          cmd_idx = ce.inv ? ie[bctd_pkg::LANE_INV] : ie[bctd_pkg::LANE_BEST];
          res_done.slot = bctd_pkg::SLOT_W'(cmd_idx);
          res_done.fill_needed = item.opcode == bctd_pkg::OP_READ;
          // victim is valid only when no free entry was seen
          if (!ce.inv && ce.best_dirty) begin
            res_done.writeback_valid  = 1'b1;
            res_done.writeback_tag    = ce.best_tag;
            res_done.writeback_offset = ce.best_off;
          end
        end
      end else if (ce.wb && (n_res < RES_W'(bctd_pkg::MAX_RESULTS))) begin
        cmd     = bctd_pkg::CMD_CLEAN;
        cmd_idx = ie[bctd_pkg::LANE_WB];
        more    = 1'b1;
      end else begin
        cmd = bctd_pkg::CMD_BULK;
      end
    end
  end

  // result of a spare opcode or a disabled cache, and of a held write-back
  always_comb begin
    res_start      = '0;
    res_start.last = 1'b1;
    if ((request.payload.opcode <= bctd_pkg::OP_INV_ALL) && !enable) begin
      res_start.status = bctd_pkg::ST_DISABLED;
    end
    res_wb      = '0;
    res_wb.last = !more;
    if (pend_valid) begin
      res_wb.writeback_valid  = 1'b1;
      res_wb.writeback_tag    = pend_tag;
      res_wb.writeback_offset = pend_off;
    end
  end

  always_comb begin
    bc.opcode       = item.opcode;
    bc.file_tag     = item.file_tag;
    bc.block_offset = item.block_offset;
    bc.mark_dirty   = item.mark_dirty;
    bc.flush_first  = item.flush_first;
    bc.clock        = clock;
    bc.cmd          = cmd;
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    bctd_cell #(
      .ENTRIES    (ENTRIES),
      .CELL_INDEX (g)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .bc        (bc),
      .cmd_idx   (cmd_idx),
      .carry_in  (chain_c[g]),
      .idx_in    (chain_i[g]),
      .carry_out (chain_c[g+1]),
      .idx_out   (chain_i[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b0;
    end else if (cfg.valid) begin
      enable <= cfg.payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      ret_state  <= IDLE;
      clock      <= 32'd1;
      cnt        <= '0;
      n_res      <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        out_q     <= res_q;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        IDLE: begin
          if (request.valid) begin
            item       <= request.payload;
            cnt        <= '0;
            n_res      <= '0;
            pend_valid <= 1'b0;
            res_q      <= res_start;
            ret_state  <= IDLE;
            if (request.payload.opcode > bctd_pkg::OP_INV_ALL) begin
              state <= EMIT;
            end else if (!enable) begin
              state <= EMIT;
            end else begin
              if (((request.payload.opcode == bctd_pkg::OP_READ) ||
                   (request.payload.opcode == bctd_pkg::OP_WRITE)) &&
                  request.payload.new_request) begin
                clock <= (clock == 32'hFFFF_FFFF) ? 32'd1 : clock + 32'd1;
              end
              state <= SCAN;
            end
          end
        end
        SCAN: begin
          if (cnt == CNT_W'(ENTRIES - 1)) begin
            state <= DONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        DONE: begin
          cnt <= '0;
          if (rw) begin
            res_q     <= res_done;
            ret_state <= IDLE;
            state     <= EMIT;
          end else if (more) begin
            // hold the newest write-back until we know whether it is the last
            pend_valid <= 1'b1;
            pend_tag   <= ce.wb_tag;
            pend_off   <= ce.wb_off;
            n_res      <= n_res + 1'b1;
            if (pend_valid) begin
              res_q     <= res_wb;
              ret_state <= SCAN;
              state     <= EMIT;
            end else begin
              state <= SCAN;
            end
          end else begin
            res_q     <= res_wb;
            ret_state <= IDLE;
            state     <= EMIT;
          end
        end
        EMIT: begin
          if (load) begin
            cnt   <= '0;
            state <= ret_state;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule
